// ===== sv/mse_pkg.sv =====
// mse_pkg: shared constants of the merge sort engine
// no dependencies; imported by the interfaces and the top level
package mse_pkg;

  localparam int unsigned MAX_ITEMS_DEF  = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

endpackage

// ===== sv/mse_if.sv =====
// mse_item_if and mse_sorted_if: valid/ready channels of the merge sort engine
// depends on mse_pkg for the default value width
interface mse_item_if #(
  parameter int unsigned VALUE_BITS = mse_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] item_value;
  logic                  item_last;

  modport source (output valid, output item_value, output item_last, input ready);
  modport sink   (input valid, input item_value, input item_last, output ready);
endinterface

interface mse_sorted_if #(
  parameter int unsigned VALUE_BITS = mse_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] sorted_value;
  logic                  sorted_last;
  logic                  dropped_flag;

  modport source (output valid, output sorted_value, output sorted_last,
                  output dropped_flag, input ready);
  modport sink   (input valid, input sorted_value, input sorted_last,
                  input dropped_flag, output ready);
endinterface

// ===== sv/merge_sort_engine.sv =====
// merge_sort_engine: a set is loaded one value per cycle into RAM A; the item marked
// last starts a bottom-up merge sort that moves runs between RAM A and RAM B, one
// element per cycle through the single write port of the destination RAM, with a
// set-up state (ST_BLOCK) before each pair of runs. A set of n values takes
// ceil(log2 n) passes; then each result is loaded (ST_OUT_LOAD) and shown
// (ST_OUT_SHOW) until the sink takes it. A set of one value skips the sort and is
// offered in the cycle after it is taken. Loading stops while a set is sorted and
// emitted. Values beyond MAX_ITEMS are dropped and every result of that set carries dropped_flag.
// depends on mse_pkg, mse_if, mse_ram
module merge_sort_engine #(
  parameter int unsigned MAX_ITEMS  = mse_pkg::MAX_ITEMS_DEF,
  parameter int unsigned VALUE_BITS = mse_pkg::VALUE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mse_item_if.sink     item_i,
  mse_sorted_if.source sorted_o
);
  import mse_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SUM_W  = CNT_W + 2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BLOCK,
    ST_MERGE,
    ST_OUT_LOAD,
    ST_OUT_SHOW
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic [CNT_W:0]        width_q, width_d;
  logic                  src_sel_q, src_sel_d;
  logic [CNT_W-1:0]      k_q, k_d;
  logic [CNT_W-1:0]      i_q, i_d;
  logic [CNT_W-1:0]      j_q, j_d;
  logic [CNT_W-1:0]      mid_q, mid_d;
  logic [CNT_W-1:0]      hi_q, hi_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_value_q, out_value_d;
  logic                  out_last_q, out_last_d;
  logic                  out_drop_q, out_drop_d;

  logic                  load_we, merge_we;
  logic [CNT_W-1:0]      count_inc;
  logic [VALUE_BITS-1:0] rd_a0, rd_a1, rd_b0, rd_b1, src0, src1, merged;
  logic [SUM_W-1:0]      sum_mid, sum_hi, n_ext;
  logic [CNT_W-1:0]      mid_calc, hi_calc;
  logic                  take_left;

  logic                  we_a, we_b;
  logic [ADDR_W-1:0]     waddr_a;
  logic [VALUE_BITS-1:0] wdata_a;

  assign src0 = src_sel_q ? rd_b0 : rd_a0;
  assign src1 = src_sel_q ? rd_b1 : rd_a1;

  // run bounds of the next pair, clamped to the set size
  assign sum_mid  = SUM_W'(k_q) + SUM_W'(width_q);
  assign sum_hi   = SUM_W'(k_q) + SUM_W'({width_q, 1'b0});
  assign n_ext    = SUM_W'(count_q);
  assign mid_calc = (sum_mid > n_ext) ? count_q : sum_mid[CNT_W-1:0];
  assign hi_calc  = (sum_hi > n_ext) ? count_q : sum_hi[CNT_W-1:0];

  // left run wins on equal values
  assign take_left = (i_q < mid_q) &&
                     ((j_q >= hi_q) || ($signed(src0) <= $signed(src1)));
  assign merged    = take_left ? src0 : src1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    width_d     = width_q;
    src_sel_d   = src_sel_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;
    load_we     = 1'b0;
    merge_we    = 1'b0;
    count_inc   = count_q;

    case (state_q)
      ST_LOAD: begin
        if (item_i.valid) begin
          if (count_q < CNT_W'(MAX_ITEMS)) begin
            load_we   = 1'b1;
            count_inc = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          count_d = count_inc;
          if (item_i.item_last) begin
            if (count_inc <= CNT_W'(1)) begin
              // a lone value is still being written, so it goes straight out
              out_valid_d = 1'b1;
              out_value_d = item_i.item_value;
              out_last_d  = 1'b1;
              out_drop_d  = ovf_d;
              state_d     = ST_OUT_SHOW;
            end else begin
              width_d   = (CNT_W + 1)'(1);
              k_d       = '0;
              src_sel_d = 1'b0;
              state_d   = ST_BLOCK;
            end
          end
        end
      end
      ST_BLOCK: begin
        mid_d   = mid_calc;
        hi_d    = hi_calc;
        i_d     = k_q;
        j_d     = mid_calc;
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        merge_we = 1'b1;
        if (take_left) begin
          i_d = i_q + CNT_W'(1);
        end else begin
          j_d = j_q + CNT_W'(1);
        end
        k_d = k_q + CNT_W'(1);
        if (k_q + CNT_W'(1) == hi_q) begin
          if (hi_q == count_q) begin
            // pass done: destination becomes the source of the next pass
            width_d   = {width_q[CNT_W-1:0], 1'b0};
            src_sel_d = ~src_sel_q;
            k_d       = '0;
            if ({width_q, 1'b0} < n_ext) begin
              state_d = ST_BLOCK;
            end else begin
              i_d     = '0;
              state_d = ST_OUT_LOAD;
            end
          end else begin
            state_d = ST_BLOCK;
          end
        end
      end
      ST_OUT_LOAD: begin
        out_valid_d = 1'b1;
        out_value_d = src0;
        out_last_d  = (i_q + CNT_W'(1) == count_q);
        out_drop_d  = ovf_q;
        state_d     = ST_OUT_SHOW;
      end
      ST_OUT_SHOW: begin
        if (sorted_o.ready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = ST_OUT_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      width_q     <= '0;
      src_sel_q   <= 1'b0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      width_q     <= width_d;
      src_sel_q   <= src_sel_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
      out_value_q <= out_value_d;
      out_last_q  <= out_last_d;
      out_drop_q  <= out_drop_d;
    end
  end

  // within a pass reads go to one RAM and writes to the other, so no forwarding
  assign we_a    = load_we || (merge_we && src_sel_q);
  assign we_b    = merge_we && !src_sel_q;
  assign waddr_a = load_we ? count_q[ADDR_W-1:0] : k_q[ADDR_W-1:0];
  assign wdata_a = load_we ? item_i.item_value : merged;

  mse_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_ram_a (
    .clk_i     (clk_i),
    .we_i      (we_a),
    .waddr_i   (waddr_a),
    .wdata_i   (wdata_a),
    .raddr_a_i (i_d[ADDR_W-1:0]),
    .raddr_b_i (j_d[ADDR_W-1:0]),
    .rdata_a_o (rd_a0),
    .rdata_b_o (rd_a1)
  );

  mse_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_ram_b (
    .clk_i     (clk_i),
    .we_i      (we_b),
    .waddr_i   (k_q[ADDR_W-1:0]),
    .wdata_i   (merged),
    .raddr_a_i (i_d[ADDR_W-1:0]),
    .raddr_b_i (j_d[ADDR_W-1:0]),
    .rdata_a_o (rd_b0),
    .rdata_b_o (rd_b1)
  );

  assign item_i.ready          = (state_q == ST_LOAD);
  assign sorted_o.valid        = out_valid_q;
  assign sorted_o.sorted_value = out_value_q;
  assign sorted_o.sorted_last  = out_last_q;
  assign sorted_o.dropped_flag = out_drop_q;

endmodule

// ===== sv/mse_ram.sv =====
// mse_ram: generic single-write, dual-read synchronous RAM with registered reads
// no dependencies
module mse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== sv/mse_chk.sv =====
// mse_chk: port-level assertions for merge_sort_engine, with the bind that attaches them
// depends on merge_sort_engine and mse_if
module mse_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic item_valid_i,
  input logic item_ready_i,
  input logic item_last_i,
  input logic sorted_valid_i,
  input logic sorted_ready_i,
  input logic sorted_last_i
);

  // a pending result stays offered until taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sorted_valid_i && !sorted_ready_i) |=> sorted_valid_i)
    else $error("result withdrawn before it was taken");

  // no new request is taken while a set is being emitted
  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sorted_valid_i |-> !item_ready_i)
    else $error("input ready while a result is offered");

  // the closing request of a set starts the sort, so loading stops
  a_last_stops_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && item_ready_i && item_last_i) |=> !item_ready_i)
    else $error("input still ready after the set was closed");

  // nothing follows the final result of a set until a new set arrives
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sorted_valid_i && sorted_ready_i && sorted_last_i) |=> !sorted_valid_i)
    else $error("result offered right after the final one");

endmodule

bind merge_sort_engine mse_chk u_mse_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .item_valid_i   (item_i.valid),
  .item_ready_i   (item_i.ready),
  .item_last_i    (item_i.item_last),
  .sorted_valid_i (sorted_o.valid),
  .sorted_ready_i (sorted_o.ready),
  .sorted_last_i  (sorted_o.sorted_last)
);

// ===== bench/merge_sort_engine_tb.sv =====
// merge_sort_engine_tb: self-checking bench for the merge sort engine, with its own
// stable-sort predictor, a directed table, random sets, an overflowing set and back-pressure
// depends on mse_pkg, mse_if and merge_sort_engine
module merge_sort_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mse_pkg::*;

  localparam int unsigned MAX_ITEMS  = MAX_ITEMS_DEF;
  localparam int unsigned VALUE_BITS = VALUE_BITS_DEF;
  localparam int ITEM_TARGET   = 270;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 6000;
  localparam int SETTLE_CYCLES = 40;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   dropped;
  } sorted_rec_t;

  typedef struct packed {
    value_t      value;
    logic        last;
    logic        typed;
    sorted_rec_t want;
  } stim_row_t;

  localparam int N_DIRECTED = 17;
  // single-value sets carry their result in the row, the others go through the predictor
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{32'sh7FFF_FFFF, 1'b1, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0}},
    '{32'sh8000_0000, 1'b1, 1'b1, '{32'sh8000_0000, 1'b1, 1'b0}},
    '{32'sh0000_0000, 1'b1, 1'b1, '{32'sh0000_0000, 1'b1, 1'b0}},
    '{32'shFFFF_FFFF, 1'b1, 1'b1, '{32'shFFFF_FFFF, 1'b1, 1'b0}},
    '{32'shFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'sh0000_0001, 1'b0, 1'b0, '0},
    '{32'sh8000_0000, 1'b0, 1'b0, '0},
    '{32'sh7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'shFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'sh0000_0000, 1'b1, 1'b0, '0},
    '{32'sh0000_0005, 1'b0, 1'b0, '0},
    '{32'sh0000_0005, 1'b1, 1'b0, '0},
    '{32'sh4000_0000, 1'b0, 1'b0, '0},
    '{32'sh0001_0000, 1'b0, 1'b0, '0},
    '{32'sh0000_0002, 1'b0, 1'b0, '0},
    '{32'shFFFF_FFFE, 1'b0, 1'b0, '0},
    '{32'shC000_0000, 1'b1, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  mse_item_if   item_ch ();
  mse_sorted_if sorted_ch ();

  merge_sort_engine dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_ch),
    .sorted_o (sorted_ch)
  );

  // predictor state: the set being collected and the sorted values still to come
  value_t      set_values [$];
  bit          set_overflow;
  sorted_rec_t pending_sorted [$];

  // a directed row with its result typed in
  bit          row_typed;
  sorted_rec_t row_want;

  bit hold_req;
  int errors;
  int sets_closed;
  int overflow_sets;
  int values_checked;
  int items_sent;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // append one expected result to the tail of the queue
  function automatic void queue_result(sorted_rec_t rec);
    pending_sorted = {pending_sorted, rec};
  endfunction

  // store one value; on the last one, sort the set stably and, if emit is set, queue every result
  function automatic void take_value(value_t v, bit last, bit emit);
    value_t ordered [MAX_ITEMS];
    value_t x;
    int     n;
    int     j;
    if (set_values.size() < MAX_ITEMS) set_values = {set_values, v};
    else set_overflow = 1'b1;
    if (!last) return;
    n = set_values.size();
    for (int i = 0; i < n; i++) begin
      x = set_values[i];
      j = i;
      // strictly greater only, so equal values keep their arrival order
      while (j > 0 && ordered[j-1] > x) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = x;
    end
    if (emit) begin
      for (int k = 0; k < n; k++) begin
        queue_result('{ordered[k], k == n - 1, set_overflow});
      end
    end
    sets_closed++;
    if (set_overflow) overflow_sets++;
    set_values.delete();
    set_overflow = 1'b0;
  endfunction

  // accepted requests on both channels, result checks and the stall watchdog
  always @(posedge clk) begin
    sorted_rec_t want;
    bit          moved;
    moved = 1'b0;
    if (rst_n) begin
      if (item_ch.valid && item_ch.ready) begin
        take_value(item_ch.item_value, item_ch.item_last, !row_typed);
        if (row_typed && item_ch.item_last) queue_result(row_want);
        moved = 1'b1;
      end
      if (sorted_ch.valid && sorted_ch.ready) begin
        moved = 1'b1;
        if (pending_sorted.size() == 0) begin
          report_mismatch($sformatf("unexpected result, value %0d",
                                    $signed(sorted_ch.sorted_value)));
        end else begin
          want = pending_sorted.pop_front();
          values_checked++;
          if (sorted_ch.sorted_value !== want.value)
            report_mismatch($sformatf("sorted_value got %0d expected %0d",
                                      $signed(sorted_ch.sorted_value), want.value));
          if (sorted_ch.sorted_last !== want.last)
            report_mismatch($sformatf("sorted_last got %b expected %b",
                                      sorted_ch.sorted_last, want.last));
          if (sorted_ch.dropped_flag !== want.dropped)
            report_mismatch($sformatf("dropped_flag got %b expected %b",
                                      sorted_ch.dropped_flag, want.dropped));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("merge_sort_engine_tb: FAIL");
        $finish;
      end
    end
  end

  // receiver: rotating stall patterns, plus one long hold-off on request
  initial begin
    int cyc;
    int hold_left;
    bit rdy;
    sorted_ch.ready = 1'b0;
    cyc = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else begin
        case ((cyc / 97) % 4)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          2: rdy = ($urandom_range(0, 3) != 0);
          default: rdy = ((cyc % 7) < 3);
        endcase
      end
      sorted_ch.ready <= rdy;
    end
  end

  task automatic send_item(value_t v, bit last);
    item_ch.valid      <= 1'b1;
    item_ch.item_value <= v;
    item_ch.item_last  <= last;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender(int cycles);
    item_ch.valid      <= 1'b0;
    item_ch.item_value <= $urandom;
    item_ch.item_last  <= $urandom_range(0, 1);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    idle_sender(1);
    while (pending_sorted.size() != 0) @(negedge clk);
  endtask

  function automatic value_t pick_value(int flavour);
    case (flavour)
      0: return value_t'($urandom);
      1: return value_t'($urandom_range(0, 6)) - 3;
      default: begin
        case ($urandom_range(0, 4))
          0: return {1'b0, {(VALUE_BITS-1){1'b1}}};
          1: return {1'b1, {(VALUE_BITS-1){1'b0}}};
          2: return value_t'($urandom_range(0, 2)) - 1;
          default: return value_t'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic int pick_set_size(int set_idx);
    if (set_idx == 4) return MAX_ITEMS;
    if (set_idx == 10) return MAX_ITEMS + 2;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 6);
      6, 7, 8: return $urandom_range(7, 16);
      default: return $urandom_range(17, 32);
    endcase
  endfunction

  initial begin
    int set_idx;
    int set_size;
    int flavour;
    int burst_left;
    bit steady;
    item_ch.valid      = 1'b0;
    item_ch.item_value = '0;
    item_ch.item_last  = 1'b0;
    rst_n          = 1'b0;
    row_typed      = 1'b0;
    row_want       = '0;
    hold_req       = 1'b0;
    set_overflow   = 1'b0;
    errors         = 0;
    sets_closed    = 0;
    overflow_sets  = 0;
    values_checked = 0;
    items_sent     = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table, back to back
    for (int i = 0; i < N_DIRECTED; i++) begin
      row_typed = DIRECTED_ROWS[i].typed;
      row_want  = DIRECTED_ROWS[i].want;
      send_item(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last);
    end
    row_typed = 1'b0;
    drain_results();

    // random sets in bursts; one full set and one overflowing set among them
    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      set_idx++;
      set_size = pick_set_size(set_idx);
      flavour  = $urandom_range(0, 2);
      steady   = (set_idx >= 15 && set_idx < 19);
      if (set_idx == 6) hold_req = 1'b1;
      for (int k = 0; k < set_size; k++) begin
        if (burst_left == 0) begin
          if (!steady) idle_sender($urandom_range(1, 6));
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_item(pick_value(flavour), k == set_size - 1);
      end
      if (set_idx == 3 || set_idx == 12 || set_idx == 20) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("sorted %0d sets from %0d values, %0d of them overflowing; %0d results checked",
             sets_closed, items_sent, overflow_sets, values_checked);
    $display("run included a full set, a long receiver hold-off and drained pauses");
    if (errors == 0 && pending_sorted.size() == 0) begin
      $display("merge_sort_engine_tb: PASS");
    end else begin
      $display("merge_sort_engine_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mse_pkg.sv
sv/mse_if.sv
sv/mse_ram.sv
sv/merge_sort_engine.sv
sv/mse_chk.sv
bench/merge_sort_engine_tb.sv
